// ===== hw/rtl/h2df_pkg.sv =====
// ----------------------------------------------------------------------------
// h2df_pkg
// Frame type, flag, result kind and fault codes for the HTTP/2 deframer.
// ----------------------------------------------------------------------------
package h2df_pkg;

  localparam int HdrBytes     = 9;
  localparam int SettingBytes = 6;
  localparam int FixedWord    = 4;

  localparam logic [7:0] T_DATA     = 8'd0;
  localparam logic [7:0] T_HEADERS  = 8'd1;
  localparam logic [7:0] T_RST      = 8'd3;
  localparam logic [7:0] T_SETTINGS = 8'd4;
  localparam logic [7:0] T_PUSH     = 8'd5;
  localparam logic [7:0] T_GOAWAY   = 8'd7;
  localparam logic [7:0] T_WINDOW   = 8'd8;
  localparam logic [7:0] T_CONT     = 8'd9;

  localparam int F_ES   = 0;
  localparam int F_EH   = 2;
  localparam int F_PAD  = 3;
  localparam int F_PRIO = 5;

  typedef enum logic [1:0] {
    K_CONTENT = 2'd0,
    K_SETTING = 2'd1,
    K_DONE    = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE    = 2'd0,
    E_PROTO   = 2'd1,
    E_SIZE    = 2'd2,
    E_UNKNOWN = 2'd3
  } fault_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_kind;
    logic [31:0] stream_number;
    logic [7:0]  data_byte;
    logic        end_stream_flag;
    logic        ack_flag;
    logic        priority_present;
    logic [31:0] value_a;
    logic [31:0] value_b;
    fault_t      fault;
  } result_t;

endpackage

// ===== hw/rtl/http2_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// http2_frame_deframer_unit
// Parses an HTTP/2 byte stream into content bytes, settings and frame results.
// ----------------------------------------------------------------------------
// channel | ports                                   | direction
// in      | in_valid, in_ready, in_byte             | byte stream in
// out     | out_valid, out_ready, out_kind .. last  | result words out
//
// One byte per cycle: a byte is parsed in the cycle it is accepted and its
// results (zero, one or two) land in a two-entry result queue.
// A byte is taken whenever the queue has room for two words; results drain
// one per cycle while out_ready is high, so bytes giving two results can slow intake.
// Synchronous active-low reset clears all parser state and the queue.
// A protocol or size error halts the parser until reset (bytes still drain).
// ----------------------------------------------------------------------------
module http2_frame_deframer_unit
  import h2df_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_frame_kind,
  output logic [31:0] out_stream_number,
  output logic [7:0]  out_data_byte,
  output logic        out_end_stream_flag,
  output logic        out_ack_flag,
  output logic        out_priority_present,
  output logic [31:0] out_value_a,
  output logic [31:0] out_value_b,
  output logic [1:0]  out_fault,
  output logic        out_last
);

  // parser state
  logic [3:0]  hidx_r, hidx_nxt;
  logic [23:0] flen_r, flen_nxt;
  logic [7:0]  fcode_r, fcode_nxt;
  logic [7:0]  fflag_r, fflag_nxt;
  logic [31:0] fsid_r, fsid_nxt;
  logic [23:0] left_r, left_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  fpos_r, fpos_nxt;
  logic        bpend_r, bpend_nxt;
  logic [7:0]  pcode_r, pcode_nxt;
  logic [31:0] psid_r, psid_nxt;
  logic [63:0] pval_r, pval_nxt;
  logic [1:0]  pflg_r, pflg_nxt;
  logic        halt_r, halt_nxt;

  // two-entry result queue
  result_t     q_r [2];
  logic        qlast_r [2];
  logic [1:0]  qcnt_r;
  logic        qhead_r;

  logic        acc_in, pop;
  result_t     r0, r1;
  logic        v0, v1;

  assign in_ready = (qcnt_r == 2'd0) || (qcnt_r == 2'd1 && out_ready);
  assign acc_in   = in_valid && in_ready;
  assign out_valid = (qcnt_r != 2'd0);
  assign pop      = out_valid && out_ready;

  function automatic result_t mk(kind_t k, logic [7:0] fk, logic [31:0] sid,
                                 logic [7:0] db, logic es, logic ack, logic pp,
                                 logic [31:0] va, logic [31:0] vb, fault_t f);
    result_t r;
    r.kind = k; r.frame_kind = fk; r.stream_number = sid; r.data_byte = db;
    r.end_stream_flag = es; r.ack_flag = ack; r.priority_present = pp;
    r.value_a = va; r.value_b = vb; r.fault = f;
    return r;
  endfunction

  // multiple of 6: even, and the base-256 digit sum divisible by 3
  function automatic logic len_mult6(logic [23:0] v);
    logic [9:0] s1;
    logic [3:0] s2;
    logic       m3;
    s1 = {2'd0, v[23:16]} + {2'd0, v[15:8]} + {2'd0, v[7:0]};
    s2 = {2'd0, s1[9:8]} + {2'd0, s1[7:6]} + {2'd0, s1[5:4]} + {2'd0, s1[3:2]} +
         {2'd0, s1[1:0]};
    case (s2)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m3 = 1'b1;
      default:                              m3 = 1'b0;
    endcase
    return m3 && !v[0];
  endfunction

  // parser combinational step
  always_comb begin
    logic [23:0] len;
    logic [7:0]  t, f;
    logic [30:0] sid;
    logic        haspad, known, fin;
    logic [3:0]  pre;
    fault_t      flt;
    logic [63:0] acc;
    logic [31:0] va, vb, lo;
    logic        es, pp;
    logic [23:0] left1;
    logic [31:0] fs;

    hidx_nxt = hidx_r; flen_nxt = flen_r; fcode_nxt = fcode_r; fflag_nxt = fflag_r;
    fsid_nxt = fsid_r; left_nxt = left_r; pad_nxt = pad_r; acc_nxt = acc_r;
    fpos_nxt = fpos_r; bpend_nxt = bpend_r; pcode_nxt = pcode_r; psid_nxt = psid_r;
    pval_nxt = pval_r; pflg_nxt = pflg_r; halt_nxt = halt_r;
    v0 = 1'b0; v1 = 1'b0;
    r0 = '0; r1 = '0;
    fin = 1'b0;
    flt = E_NONE;
    lo = acc_r[31:0]; va = 32'd0; vb = 32'd0; es = 1'b0; pp = 1'b0;
    len = flen_r; t = fcode_r; f = fflag_r; fs = fsid_r;
    left1 = left_r - 24'd1;

    if (left_r == 24'd0) begin
      // header collection; the last byte is folded in for the checks
      if (hidx_r == 4'd0) len = {16'd0, in_byte};
      else if (hidx_r < 4'd3) len = {flen_r[15:0], in_byte};
      else if (hidx_r == 4'd3) t = in_byte;
      else if (hidx_r == 4'd4) f = in_byte;
      else if (hidx_r == 4'd5) fs = {24'd0, in_byte};
      else fs = {fsid_r[23:0], in_byte};
      flen_nxt = len; fcode_nxt = t; fflag_nxt = f; fsid_nxt = fs;
    end

    haspad = (t == T_DATA || t == T_HEADERS || t == T_PUSH) && f[F_PAD];
    known  = (t == T_DATA || t == T_HEADERS || t == T_RST || t == T_SETTINGS ||
              t == T_PUSH || t == T_GOAWAY || t == T_WINDOW || t == T_CONT);
    case (t)
      T_HEADERS:        pre = {3'd0, haspad} + (f[F_PRIO] ? 4'd5 : 4'd0);
      T_PUSH:           pre = {3'd0, haspad} + 4'(FixedWord);
      T_RST, T_WINDOW:  pre = 4'(FixedWord);
      T_GOAWAY:         pre = 4'(2 * FixedWord);
      default:          pre = {3'd0, haspad};
    endcase
    sid = fs[30:0];
    acc = acc_r;

    if (halt_r) begin
      hidx_nxt = hidx_r; flen_nxt = flen_r; fcode_nxt = fcode_r;
      fflag_nxt = fflag_r; fsid_nxt = fsid_r;
    end else if (left_r == 24'd0) begin
      if (hidx_r == 4'(HdrBytes - 1)) begin
        hidx_nxt = 4'd0;
        if (bpend_r) begin
          if (t != T_CONT || sid != psid_r[30:0]) flt = E_PROTO;
        end else if (t == T_CONT) flt = E_PROTO;
        if (flt == E_NONE) begin
          case (t)
            T_SETTINGS:
              if (sid != 31'd0) flt = E_PROTO;
              else if (f[F_ES] && len != 24'd0) flt = E_SIZE;
              else if (!len_mult6(len)) flt = E_SIZE;
            T_DATA, T_HEADERS, T_PUSH:
              if (sid == 31'd0) flt = E_PROTO;
              else if (len < {20'd0, pre}) flt = E_SIZE;
            T_WINDOW:
              if (len != 24'(FixedWord)) flt = E_SIZE;
            T_RST:
              if (len != 24'(FixedWord)) flt = E_SIZE;
              else if (sid == 31'd0) flt = E_PROTO;
            T_GOAWAY:
              if (sid != 31'd0) flt = E_PROTO;
              else if (len < 24'(2 * FixedWord)) flt = E_SIZE;
            default: ;
          endcase
        end
        if (flt == E_NONE) begin
          left_nxt = len; pad_nxt = 8'd0; fpos_nxt = 4'd0;
          acc = 64'd0; acc_nxt = 64'd0;
          fin = (len == 24'd0);
        end
      end else begin
        hidx_nxt = hidx_r + 4'd1;
      end
    end else begin
      left_nxt = left1;
      if (t == T_SETTINGS) begin
        acc = {acc_r[55:0], in_byte};
        acc_nxt = acc;
        fpos_nxt = fpos_r + 4'd1;
        if (fpos_r == 4'(SettingBytes - 1)) begin
          v0 = 1'b1;
          r0 = mk(K_SETTING, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, acc[31:0],
                  {16'd0, acc[47:32]}, E_NONE);
          fpos_nxt = 4'd0; acc_nxt = 64'd0;
        end
      end else if (known) begin
        if (haspad && fpos_r == 4'd0) begin
          fpos_nxt = 4'd1;
          // pad must fit in what remains after the rest of the prefix
          if ({16'd0, in_byte} > left1 - {20'd0, pre - 4'd1}) flt = E_PROTO;
          else pad_nxt = in_byte;
        end else if (fpos_r < pre) begin
          acc = {acc_r[55:0], in_byte};
          acc_nxt = acc;
          fpos_nxt = fpos_r + 4'd1;
        end else if (left_r > {16'd0, pad_r}) begin
          es = 1'b0;
          if (t == T_DATA || t == T_HEADERS) es = f[F_ES];
          else if (t == T_CONT) es = pflg_r[0];
          v0 = 1'b1;
          r0 = mk(K_CONTENT, t, fs, in_byte, es, 1'b0, 1'b0, 32'd0, 32'd0, E_NONE);
        end
      end
      if (flt == E_NONE) fin = (left1 == 24'd0);
    end

    if (flt != E_NONE) begin
      halt_nxt = 1'b1;
      v0 = 1'b1;
      r0 = mk(K_ERROR, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, flt);
    end else if (fin) begin
      lo = acc[31:0];
      va = 32'd0; vb = 32'd0; es = 1'b0; pp = 1'b0;
      v1 = 1'b1;
      case (t)
        T_DATA:
          r1 = mk(K_DONE, t, fs, 8'd0, f[F_ES], 1'b0, 1'b0, 32'd0, 32'd0, E_NONE);
        T_HEADERS, T_PUSH: begin
          if (t == T_HEADERS) begin
            es = f[F_ES];
            if (f[F_PRIO]) begin
              pp = 1'b1; va = acc[39:8]; vb = {24'd0, acc[7:0]};
            end
          end else begin
            va = {1'b0, lo[30:0]};
          end
          if (f[F_EH]) begin
            r1 = mk(K_DONE, t, fs, 8'd0, es, 1'b0, pp, va, vb, E_NONE);
          end else begin
            v1 = 1'b0;
            bpend_nxt = 1'b1; pcode_nxt = t; psid_nxt = fs;
            pval_nxt = {va, vb}; pflg_nxt = {pp, es};
          end
        end
        T_CONT:
          if (f[F_EH]) begin
            bpend_nxt = 1'b0;
            r1 = mk(K_DONE, pcode_r, psid_r, 8'd0, pflg_r[0], 1'b0, pflg_r[1],
                    pval_r[63:32], pval_r[31:0], E_NONE);
          end else begin
            v1 = 1'b0;
          end
        T_RST:
          r1 = mk(K_DONE, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, lo, 32'd0, E_NONE);
        T_WINDOW:
          r1 = mk(K_DONE, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, {1'b0, lo[30:0]}, 32'd0,
                  E_NONE);
        T_GOAWAY:
          r1 = mk(K_DONE, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, {1'b0, acc[62:32]}, lo,
                  E_NONE);
        T_SETTINGS:
          r1 = mk(K_DONE, t, fs, 8'd0, 1'b0, f[F_ES], 1'b0, 32'd0, 32'd0, E_NONE);
        default:
          r1 = mk(K_ERROR, t, fs, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, E_UNKNOWN);
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r <= '0; flen_r <= '0; fcode_r <= '0; fflag_r <= '0; fsid_r <= '0;
      left_r <= '0; pad_r <= '0; acc_r <= '0; fpos_r <= '0; bpend_r <= 1'b0;
      pcode_r <= '0; psid_r <= '0; pval_r <= '0; pflg_r <= '0; halt_r <= 1'b0;
    end else if (acc_in) begin
      hidx_r <= hidx_nxt; flen_r <= flen_nxt; fcode_r <= fcode_nxt;
      fflag_r <= fflag_nxt; fsid_r <= fsid_nxt; left_r <= left_nxt;
      pad_r <= pad_nxt; acc_r <= acc_nxt; fpos_r <= fpos_nxt;
      bpend_r <= bpend_nxt; pcode_r <= pcode_nxt; psid_r <= psid_nxt;
      pval_r <= pval_nxt; pflg_r <= pflg_nxt; halt_r <= halt_nxt;
    end
  end

  // result queue: push up to two words, pop one
  logic [1:0] npush;
  logic       wslot;
  assign npush = acc_in ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
  // tail slot does not move on a pop
  assign wslot = qhead_r ^ qcnt_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r  <= '0;
      qhead_r <= 1'b0;
    end else begin
      qcnt_r  <= qcnt_r + npush - {1'b0, pop};
      if (pop) qhead_r <= ~qhead_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      if (v0) begin
        q_r[wslot]     <= r0;
        qlast_r[wslot] <= ~v1;
      end
      if (v1) begin
        q_r[wslot ^ v0]     <= r1;
        qlast_r[wslot ^ v0] <= 1'b1;
      end
    end
  end

  result_t hd;
  assign hd = q_r[qhead_r];
  assign out_kind             = hd.kind;
  assign out_frame_kind       = hd.frame_kind;
  assign out_stream_number    = hd.stream_number;
  assign out_data_byte        = hd.data_byte;
  assign out_end_stream_flag  = hd.end_stream_flag;
  assign out_ack_flag         = hd.ack_flag;
  assign out_priority_present = hd.priority_present;
  assign out_value_a          = hd.value_a;
  assign out_value_b          = hd.value_b;
  assign out_fault            = hd.fault;
  assign out_last             = qlast_r[qhead_r];

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) qcnt_r != 2'd3)
    else $error("result queue overflow");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n) halt_r |=> halt_r)
    else $error("halt cleared without reset");
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && acc_in) |=> qcnt_r <= $past(qcnt_r))
    else $error("results after halt");
  a_hidx: assert property (@(posedge clk) disable iff (!rst_n)
    hidx_r < 4'(HdrBytes))
    else $error("header index out of range");

endmodule

// ===== bench/tb_http2_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_http2_frame_deframer_unit
// Streams HTTP/2 frames, byte by byte, through the deframer. A behavioral
// parser predicts every result word and the monitor compares them in order.
// ----------------------------------------------------------------------------
module tb_http2_frame_deframer_unit;
  import h2df_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_frame_kind;
  logic [31:0] out_stream_number;
  logic [7:0]  out_data_byte;
  logic        out_end_stream_flag;
  logic        out_ack_flag;
  logic        out_priority_present;
  logic [31:0] out_value_a;
  logic [31:0] out_value_b;
  logic [1:0]  out_fault;
  logic        out_last;

  http2_frame_deframer_unit DUT (.*);

  typedef struct {
    result_t r;
    logic    lst;
  } word_t;

  // predictor state
  logic [3:0]  p_hidx;
  logic [23:0] p_len;
  logic [7:0]  p_code;
  logic [7:0]  p_flags;
  logic [31:0] p_stream;
  logic [23:0] p_left;
  logic [7:0]  p_pad;
  logic [63:0] p_acc;
  logic [3:0]  p_pos;
  logic        p_blk;
  logic [7:0]  pb_code;
  logic [31:0] pb_stream;
  logic [63:0] pb_vals;
  logic [1:0]  pb_flags;
  logic        p_halt;

  logic [7:0] byte_q[$];
  word_t      expect_q[$];
  word_t      step_w[$];
  int         errors = 0;
  int         n_words = 0;
  int         n_bytes = 0;
  longint     cycles = 0;
  bit         stim_done = 0;

  initial clk = 0;
  always #1 clk = ~clk;

  function automatic void push_word(kind_t k, logic [7:0] fk, logic [31:0] sid,
                                    logic [7:0] db, logic es, logic ack, logic pp,
                                    logic [31:0] va, logic [31:0] vb, fault_t f);
    word_t w;
    w.r.kind = k; w.r.frame_kind = fk; w.r.stream_number = sid;
    w.r.data_byte = db; w.r.end_stream_flag = es; w.r.ack_flag = ack;
    w.r.priority_present = pp; w.r.value_a = va; w.r.value_b = vb;
    w.r.fault = f; w.lst = 0;
    step_w.push_back(w);
  endfunction

  function automatic bit padded();
    return (p_code == T_DATA || p_code == T_HEADERS || p_code == T_PUSH) && p_flags[F_PAD];
  endfunction

  function automatic int prefix_bytes();
    int p;
    p = padded() ? 1 : 0;
    case (p_code)
      T_HEADERS: return p + (p_flags[F_PRIO] ? 5 : 0);
      T_PUSH: return p + FixedWord;
      T_RST, T_WINDOW: return FixedWord;
      T_GOAWAY: return 2 * FixedWord;
      default: return p;
    endcase
  endfunction

  function automatic bit is_known(logic [7:0] t);
    return t inside {T_DATA, T_HEADERS, T_RST, T_SETTINGS, T_PUSH, T_GOAWAY,
                     T_WINDOW, T_CONT};
  endfunction

  function automatic void halt_on(fault_t f);
    p_halt = 1;
    push_word(K_ERROR, p_code, p_stream, 0, 0, 0, 0, 0, 0, f);
  endfunction

  function automatic void close_frame();
    logic [31:0] lo, va, vb;
    logic es, pp;
    lo = p_acc[31:0]; va = 0; vb = 0; es = 0; pp = 0;
    case (p_code)
      T_DATA: push_word(K_DONE, p_code, p_stream, 0, p_flags[F_ES], 0, 0, 0, 0, E_NONE);
      T_HEADERS, T_PUSH: begin
        if (p_code == T_HEADERS) begin
          es = p_flags[F_ES];
          if (p_flags[F_PRIO]) begin
            pp = 1; va = p_acc[39:8]; vb = {24'd0, p_acc[7:0]};
          end
        end else begin
          va = {1'b0, lo[30:0]};
        end
        if (p_flags[F_EH]) begin
          push_word(K_DONE, p_code, p_stream, 0, es, 0, pp, va, vb, E_NONE);
        end else begin
          p_blk = 1; pb_code = p_code; pb_stream = p_stream;
          pb_vals = {va, vb}; pb_flags = {pp, es};
        end
      end
      T_CONT: if (p_flags[F_EH]) begin
        p_blk = 0;
        push_word(K_DONE, pb_code, pb_stream, 0, pb_flags[0], 0, pb_flags[1],
                  pb_vals[63:32], pb_vals[31:0], E_NONE);
      end
      T_RST: push_word(K_DONE, p_code, p_stream, 0, 0, 0, 0, lo, 0, E_NONE);
      T_WINDOW: push_word(K_DONE, p_code, p_stream, 0, 0, 0, 0, {1'b0, lo[30:0]}, 0, E_NONE);
      T_GOAWAY: push_word(K_DONE, p_code, p_stream, 0, 0, 0, 0, {1'b0, p_acc[62:32]}, lo,
                          E_NONE);
      T_SETTINGS: push_word(K_DONE, p_code, p_stream, 0, 0, p_flags[F_ES], 0, 0, 0, E_NONE);
      default: push_word(K_ERROR, p_code, p_stream, 0, 0, 0, 0, 0, 0, E_UNKNOWN);
    endcase
  endfunction

  function automatic void check_header();
    logic [30:0] sid;
    fault_t f;
    sid = p_stream[30:0];
    f = E_NONE;
    if (p_blk) begin
      if (p_code != T_CONT || sid != pb_stream[30:0]) f = E_PROTO;
    end else if (p_code == T_CONT) begin
      f = E_PROTO;
    end
    if (f == E_NONE) begin
      case (p_code)
        T_SETTINGS: begin
          if (sid != 0) f = E_PROTO;
          else if (p_flags[F_ES] && p_len != 0) f = E_SIZE;
          else if (p_len % SettingBytes != 0) f = E_SIZE;
        end
        T_DATA, T_HEADERS, T_PUSH: begin
          if (sid == 0) f = E_PROTO;
          else if (p_len < prefix_bytes()) f = E_SIZE;
        end
        T_WINDOW: if (p_len != FixedWord) f = E_SIZE;
        T_RST: begin
          if (p_len != FixedWord) f = E_SIZE;
          else if (sid == 0) f = E_PROTO;
        end
        T_GOAWAY: begin
          if (sid != 0) f = E_PROTO;
          else if (p_len < 2 * FixedWord) f = E_SIZE;
        end
        default: ;
      endcase
    end
    if (f != E_NONE) begin
      halt_on(f);
      return;
    end
    p_left = p_len; p_pad = 0; p_pos = 0; p_acc = 0;
    if (p_len == 0) close_frame();
  endfunction

  function automatic void payload(logic [7:0] b);
    int p;
    logic es;
    if (p_code == T_SETTINGS) begin
      p_acc = {p_acc[55:0], b}; p_pos++; p_left--;
      if (p_pos >= SettingBytes) begin
        push_word(K_SETTING, p_code, p_stream, 0, 0, 0, 0, p_acc[31:0],
                  {16'd0, p_acc[47:32]}, E_NONE);
        p_pos = 0; p_acc = 0;
      end
    end else if (!is_known(p_code)) begin
      p_left--;
    end else begin
      p = prefix_bytes();
      if (padded() && p_pos == 0) begin
        p_pos = 1; p_left--;
        if (int'(b) > int'(p_left) - (p - 1)) begin
          halt_on(E_PROTO);
          return;
        end
        p_pad = b;
      end else if (p_pos < p) begin
        p_acc = {p_acc[55:0], b}; p_pos++; p_left--;
      end else begin
        if (p_left > p_pad) begin
          es = 0;
          if (p_code == T_DATA || p_code == T_HEADERS) es = p_flags[F_ES];
          else if (p_code == T_CONT) es = pb_flags[0];
          push_word(K_CONTENT, p_code, p_stream, b, es, 0, 0, 0, 0, E_NONE);
        end
        p_left--;
      end
    end
    if (p_left == 0) close_frame();
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    step_w.delete();
    if (p_halt) return;
    if (p_left != 0) begin
      payload(b);
    end else begin
      case (p_hidx)
        0: p_len = {16'd0, b};
        1, 2: p_len = {p_len[15:0], b};
        3: p_code = b;
        4: p_flags = b;
        5: p_stream = {24'd0, b};
        default: p_stream = {p_stream[23:0], b};
      endcase
      if (p_hidx == HdrBytes - 1) begin
        p_hidx = 0;
        check_header();
      end else begin
        p_hidx++;
      end
    end
    if (step_w.size() > 0) step_w[step_w.size()-1].lst = 1;
    foreach (step_w[i]) expect_q.push_back(step_w[i]);
  endfunction

  // stimulus builders
  task automatic put_hdr(int len, logic [7:0] t, logic [7:0] f, logic [31:0] sid);
    byte_q.push_back(len[23:16]); byte_q.push_back(len[15:8]); byte_q.push_back(len[7:0]);
    byte_q.push_back(t); byte_q.push_back(f);
    for (int i = 3; i >= 0; i--) byte_q.push_back(sid[i*8 +: 8]);
  endtask

  task automatic put_rand(int n);
    for (int i = 0; i < n; i++) byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [31:0] rsid();
    return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(1, 7))} |
           ($urandom_range(0, 7) == 0 ? 32'h7fff_fff0 : 32'h0);
  endfunction

  // one well-formed frame (or header block) with random content
  task automatic put_frame();
    int sel, clen, pad, len;
    logic [7:0] f;
    logic [31:0] sid;
    sel = $urandom_range(0, 9);
    sid = rsid();
    clen = $urandom_range(0, 6);
    pad = $urandom_range(0, 1) ? $urandom_range(0, 3) : 0;
    f = 8'($urandom_range(0, 255));
    case (sel)
      0, 1: begin
        if (!f[F_PAD]) pad = 0;
        len = clen + (f[F_PAD] ? 1 + pad : 0);
        put_hdr(len, T_DATA, f, sid);
        if (f[F_PAD]) byte_q.push_back(8'(pad));
        put_rand(clen + pad);
      end
      2, 3: begin
        if (!f[F_PAD]) pad = 0;
        len = clen + (f[F_PAD] ? 1 + pad : 0) + (f[F_PRIO] ? 5 : 0);
        put_hdr(len, T_HEADERS, f, sid);
        if (f[F_PAD]) byte_q.push_back(8'(pad));
        put_rand(len - (f[F_PAD] ? 1 : 0));
        if (!f[F_EH]) begin
          put_hdr(2, T_CONT, 8'($urandom_range(0, 255)) & ~8'h04, sid ^ 32'h8000_0000);
          put_rand(2);
          put_hdr($urandom_range(0, 3), T_CONT, 8'h04 | 8'($urandom_range(0, 255)), sid);
          put_rand(byte_q[byte_q.size()-7]);
        end
      end
      4: begin
        f[F_EH] = $urandom_range(0, 3) != 0;
        if (!f[F_PAD]) pad = 0;
        len = clen + 4 + (f[F_PAD] ? 1 + pad : 0);
        put_hdr(len, T_PUSH, f, sid);
        if (f[F_PAD]) byte_q.push_back(8'(pad));
        put_rand(len - (f[F_PAD] ? 1 : 0));
        if (!f[F_EH]) begin
          put_hdr(1, T_CONT, 8'h04, sid);
          put_rand(1);
        end
      end
      5: begin
        put_hdr(4, $urandom_range(0, 1) ? T_RST : T_WINDOW, f, sid);
        put_rand(4);
      end
      6: begin
        put_hdr(8 + clen, T_GOAWAY, f, {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0});
        put_rand(8 + clen);
      end
      7: begin
        if ($urandom_range(0, 2) == 0) begin
          put_hdr(0, T_SETTINGS, f | 8'h01, 0);
        end else begin
          len = 6 * $urandom_range(0, 2);
          put_hdr(len, T_SETTINGS, f & 8'hfe, 0);
          put_rand(len);
        end
      end
      default: begin
        put_hdr(clen, $urandom_range(0, 1) ? 8'd2 : ($urandom_range(0, 1) ? 8'd6 :
                8'($urandom_range(10, 255))), f, $urandom);
        put_rand(clen);
      end
    endcase
  endtask

  // breaks the parser on purpose; halts it until the end of the run
  task automatic put_fault();
    case ($urandom_range(0, 9))
      0: put_hdr(4, T_RST, 0, 0);
      1: put_hdr(5, T_WINDOW, 0, 1);
      2: put_hdr(6, T_SETTINGS, 1, 0);
      3: put_hdr(5, T_SETTINGS, 0, 0);
      4: put_hdr(6, T_SETTINGS, 0, 3);
      5: put_hdr(2, T_CONT, 4, 1);
      6: put_hdr(7, T_GOAWAY, 0, 0);
      7: put_hdr(3, T_PUSH, 4, 1);
      8: begin put_hdr(3, T_DATA, 8, 1); byte_q.push_back(8'd3); end
      default: put_hdr(0, T_DATA, 0, 32'h8000_0000);
    endcase
    put_rand(30);
  endtask

  initial begin
    // directed frames
    put_hdr(3, T_DATA, 8'h01, 32'h8000_0001); byte_q.push_back(8'hff);
    byte_q.push_back(8'h00); byte_q.push_back(8'h5a);
    put_hdr(4, T_DATA, 8'h08, 32'hffff_ffff); byte_q.push_back(8'd2); put_rand(3);
    put_hdr(7, T_HEADERS, 8'h25, 3); put_rand(7);
    put_hdr(5, T_PUSH, 8'h00, 5); put_rand(5);
    put_hdr(1, T_CONT, 8'h00, 32'h8000_0005); put_rand(1);
    put_hdr(0, T_CONT, 8'h04, 5);
    put_hdr(4, T_RST, 0, 7); put_rand(4);
    put_hdr(4, T_WINDOW, 0, 0); put_rand(4);
    put_hdr(9, T_GOAWAY, 0, 32'h8000_0000); put_rand(9);
    put_hdr(12, T_SETTINGS, 0, 0); put_rand(12);
    put_hdr(0, T_SETTINGS, 1, 0);
    put_hdr(0, 8'd2, 0, 1);
    put_hdr(2, 8'd6, 0, 0); put_rand(2);
    put_hdr(1, 8'hff, 0, 0); put_rand(1);
    while (byte_q.size() < 1250) put_frame();
    put_fault();
  end

  // sender: bursts with gaps
  int burst = 0;
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_byte <= 0;
    end else begin
      cycles++;
      if (in_valid && in_ready) begin
        predict_byte(in_byte);
        n_bytes++;
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (gap > 0) begin
        gap--;
        in_valid <= 0;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1;
        in_byte <= byte_q.pop_front();
        if (burst > 0) begin
          burst--;
        end else begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 0;
        if (n_bytes > 0) stim_done = 1;
      end
    end
  end

  // receiver: stall pattern plus results check
  logic [7:0] stall_pat;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      stall_pat <= 8'hff;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (expect_q.size() == 0) begin
          $error("unexpected result word kind=%0d", out_kind);
          errors++;
        end else begin
          word_t w;
          w = expect_q.pop_front();
          if (out_kind !== w.r.kind) begin
            $error("kind exp %0d got %0d", w.r.kind, out_kind); errors++;
          end
          if (out_frame_kind !== w.r.frame_kind) begin
            $error("frame_kind exp %0d got %0d", w.r.frame_kind, out_frame_kind); errors++;
          end
          if (out_stream_number !== w.r.stream_number) begin
            $error("stream_number exp %h got %h", w.r.stream_number, out_stream_number);
            errors++;
          end
          if (out_data_byte !== w.r.data_byte) begin
            $error("data_byte exp %h got %h", w.r.data_byte, out_data_byte); errors++;
          end
          if (out_end_stream_flag !== w.r.end_stream_flag) begin
            $error("end_stream_flag exp %b got %b", w.r.end_stream_flag,
                   out_end_stream_flag); errors++;
          end
          if (out_ack_flag !== w.r.ack_flag) begin
            $error("ack_flag exp %b got %b", w.r.ack_flag, out_ack_flag); errors++;
          end
          if (out_priority_present !== w.r.priority_present) begin
            $error("priority_present exp %b got %b", w.r.priority_present,
                   out_priority_present); errors++;
          end
          if (out_value_a !== w.r.value_a) begin
            $error("value_a exp %h got %h", w.r.value_a, out_value_a); errors++;
          end
          if (out_value_b !== w.r.value_b) begin
            $error("value_b exp %h got %h", w.r.value_b, out_value_b); errors++;
          end
          if (out_fault !== w.r.fault) begin
            $error("fault exp %0d got %0d", w.r.fault, out_fault); errors++;
          end
          if (out_last !== w.lst) begin
            $error("last exp %b got %b", w.lst, out_last); errors++;
          end
        end
      end
      stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ stall_pat[4] ^ stall_pat[3]};
      // long runs without stalls every so often
      out_ready <= (cycles % 2048 < 512) ? 1'b1 : (stall_pat[1:0] != 2'b00);
    end
  end

  initial begin
    p_hidx = 0; p_len = 0; p_code = 0; p_flags = 0; p_stream = 0; p_left = 0;
    p_pad = 0; p_acc = 0; p_pos = 0; p_blk = 0; pb_code = 0; pb_stream = 0;
    pb_vals = 0; pb_flags = 0; p_halt = 0;
    rst_n = 0;
    in_valid = 0;
    in_byte = 0;
    out_ready = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    while (!(stim_done && expect_q.size() == 0) && cycles < 200000) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("streamed %0d bytes of mixed frames, checked %0d result words", n_bytes,
             n_words);
    if (cycles >= 200000) begin
      $display("timeout with %0d results outstanding", expect_q.size());
      $display("Regression FAIL");
    end else if (errors == 0 && expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== http2_frame_deframer_unit.f =====
hw/rtl/h2df_pkg.sv
hw/rtl/http2_frame_deframer_unit.sv
bench/tb_http2_frame_deframer_unit.sv
